// ----- src/triangle_measures_from_sides_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the triangle measures core
// Short forms for clocked implications, gated by the async reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MEASURES_FROM_SIDES_CORE_MACROS_SVH
`define TRIANGLE_MEASURES_FROM_SIDES_CORE_MACROS_SVH

// same-cycle implication
`define TMFS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define TMFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/tmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tmfs_pkg
// Widths, stage counts and sideband types for the triangle measures core.
// ----------------------------------------------------------------------------
package tmfs_pkg;

    localparam int SIDE_BITS  = 16;
    localparam int FRAC_BITS  = 4;

    localparam int SUM_W      = SIDE_BITS + 2;          // a+b+c
    localparam int DIF_W      = SIDE_BITS + 1;          // b+c-a, b+c, 2a
    localparam int RAD_W      = 4 * SIDE_BITS + 2;      // squared-area radicand
    localparam int ROOT_W     = RAD_W / 2;
    localparam int NUM_W      = ROOT_W;
    localparam int QUO_W      = 16;
    localparam int AREA_W     = 27;
    localparam int PERIM_W    = 18;
    localparam int AREA_SHIFT = FRAC_BITS + 2;

    localparam int SQ_STAGES  = ROOT_W;                 // one root bit per stage
    localparam int DV_STAGES  = QUO_W;                  // one quotient bit per stage

    typedef struct packed {
        logic               ok;
        logic [PERIM_W-1:0] perim;
        logic [DIF_W-1:0]   dbl_a;
        logic [DIF_W-1:0]   dbl_b;
        logic [DIF_W-1:0]   dbl_c;
        logic [DIF_W-1:0]   pair_a;
        logic [DIF_W-1:0]   pair_b;
        logic [DIF_W-1:0]   pair_c;
    } side_t;

    typedef struct packed {
        logic               ok;
        logic [PERIM_W-1:0] perim;
        logic [AREA_W-1:0]  area;
        logic [QUO_W-1:0]   med_a;
        logic [QUO_W-1:0]   med_b;
        logic [QUO_W-1:0]   med_c;
    } post_t;

endpackage

// ----- src/tmfs_sqrt.sv -----
// ----------------------------------------------------------------------------
// tmfs_sqrt
// Pipelined integer square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
module tmfs_sqrt
    import tmfs_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_stage
        localparam int K = SQ_STAGES - 1 - j;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] r_in;
        logic [RAD_W+1:0]  trial;
        logic              take;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0)
        begin : g_first
            assign rem_in = rad;
            assign r_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign r_in   = root_reg[j-1];
        end

        // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
        assign trial     = ((RAD_W+2)'(r_in) << (K + 1)) + ((RAD_W+2)'(1) << (2 * K));
        assign take      = (RAD_W+2)'(rem_in) >= trial;
        assign rem_next  = take ? rem_in - trial[RAD_W-1:0] : rem_in;
        assign root_next = take ? (r_in | (ROOT_W'(1) << K)) : r_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

// ----- src/tmfs_div.sv -----
// ----------------------------------------------------------------------------
// tmfs_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module tmfs_div
    import tmfs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DIF_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [DV_STAGES];
    logic [DIF_W-1:0] den_reg [DV_STAGES];
    logic [QUO_W-1:0] quo_reg [DV_STAGES];

    for (genvar j = 0; j < DV_STAGES; j++)
    begin : g_stage
        localparam int K = DV_STAGES - 1 - j;
        logic [NUM_W-1:0] rem_in;
        logic [DIF_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic [NUM_W:0]   trial;
        logic             take;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = quo_reg[j-1];
        end

        assign trial    = (NUM_W+1)'(den_in) << K;
        assign take     = (NUM_W+1)'(rem_in) >= trial;
        assign rem_next = take ? rem_in - trial[NUM_W-1:0] : rem_in;
        assign quo_next = take ? (q_in | (QUO_W'(1) << K)) : q_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DV_STAGES-1];

endmodule

// ----- src/triangle_measures_from_sides_core.sv -----
// Pipeline: 4 setup/multiply stages, 33 square-root stages, 16 divide stages
// and 1 output register lie between an accepted beat and its result.
// Throughput: one beat per cycle; the whole pipe holds only while a finished
// result sits unaccepted in the output register.
// Reset: rst_n clears every valid bit at once; the data path needs no reset.
// ----------------------------------------------------------------------------
// triangle_measures_from_sides_core
// Triangle test, perimeter, Heron area, heights, bisectors and medians from
// three fixed-point sides, as one deep pipeline.
// ----------------------------------------------------------------------------
`include "triangle_measures_from_sides_core_macros.svh"

module triangle_measures_from_sides_core
    import tmfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [15:0]          side_a,
    input  logic [15:0]          side_b,
    input  logic [15:0]          side_c,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 is_triangle,
    output logic [AREA_W-1:0]    area,
    output logic [PERIM_W-1:0]   perimeter,
    output logic [QUO_W-1:0]     height_to_a,
    output logic [QUO_W-1:0]     height_to_b,
    output logic [QUO_W-1:0]     height_to_c,
    output logic [QUO_W-1:0]     bisector_a,
    output logic [QUO_W-1:0]     bisector_b,
    output logic [QUO_W-1:0]     bisector_c,
    output logic [QUO_W-1:0]     median_a,
    output logic [QUO_W-1:0]     median_b,
    output logic [QUO_W-1:0]     median_c
);

    // product widths
    localparam int SX_W = SUM_W + DIF_W;       // s * (b+c-a)
    localparam int YZ_W = 2 * DIF_W;           // (a+c-b)(a+b-c)
    localparam int SQ_W = 2 * SIDE_BITS;       // side products and squares
    localparam int PL_W = SX_W + DIF_W;        // split partial for the area radicand
    localparam int BL_W = SQ_W + SUM_W;        // split partial for a bisector radicand
    localparam int MV_W = SQ_W + 3;            // 2b^2 + 2c^2 - a^2

    // Global advance: everything moves unless the output beat is held.
    logic en;
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: sums, differences and the strict triangle test
    // ------------------------------------------------------------------
    logic [SIDE_BITS-1:0] a_in, b_in, c_in;
    logic [DIF_W-1:0]     pbc, pac, pab;
    side_t                side1_next;

    assign a_in = side_a[SIDE_BITS-1:0];
    assign b_in = side_b[SIDE_BITS-1:0];
    assign c_in = side_c[SIDE_BITS-1:0];
    assign pbc  = DIF_W'(b_in) + DIF_W'(c_in);
    assign pac  = DIF_W'(a_in) + DIF_W'(c_in);
    assign pab  = DIF_W'(a_in) + DIF_W'(b_in);

    always_comb
    begin
        side1_next.ok     = (DIF_W'(a_in) < pbc) && (DIF_W'(b_in) < pac)
                            && (DIF_W'(c_in) < pab);
        side1_next.perim  = PERIM_W'(pbc) + PERIM_W'(a_in);
        side1_next.dbl_a  = {a_in, 1'b0};
        side1_next.dbl_b  = {b_in, 1'b0};
        side1_next.dbl_c  = {c_in, 1'b0};
        side1_next.pair_a = pbc;
        side1_next.pair_b = pac;
        side1_next.pair_c = pab;
    end

    logic                 v1_reg;
    side_t                side1_reg;
    logic [SIDE_BITS-1:0] a1_reg, b1_reg, c1_reg;
    logic [SUM_W-1:0]     s1_reg;
    logic [DIF_W-1:0]     xa1_reg, xb1_reg, xc1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            a1_reg    <= a_in;
            b1_reg    <= b_in;
            c1_reg    <= c_in;
            s1_reg    <= SUM_W'(pbc) + SUM_W'(a_in);
            // wrap freely when the test fails; that beat is zeroed at the end
            xa1_reg   <= pbc - DIF_W'(a_in);
            xb1_reg   <= pac - DIF_W'(b_in);
            xc1_reg   <= pab - DIF_W'(c_in);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first-level products
    // ------------------------------------------------------------------
    logic              v2_reg;
    side_t             side2_reg;
    logic [SX_W-1:0]   sxa2_reg, sxb2_reg, sxc2_reg;
    logic [YZ_W-1:0]   yz2_reg;
    logic [SQ_W-1:0]   bc2_reg, ac2_reg, ab2_reg, aa2_reg, bb2_reg, cc2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side1_reg;
            sxa2_reg  <= SX_W'(s1_reg) * SX_W'(xa1_reg);
            sxb2_reg  <= SX_W'(s1_reg) * SX_W'(xb1_reg);
            sxc2_reg  <= SX_W'(s1_reg) * SX_W'(xc1_reg);
            yz2_reg   <= YZ_W'(xb1_reg) * YZ_W'(xc1_reg);
            bc2_reg   <= SQ_W'(b1_reg) * SQ_W'(c1_reg);
            ac2_reg   <= SQ_W'(a1_reg) * SQ_W'(c1_reg);
            ab2_reg   <= SQ_W'(a1_reg) * SQ_W'(b1_reg);
            aa2_reg   <= SQ_W'(a1_reg) * SQ_W'(a1_reg);
            bb2_reg   <= SQ_W'(b1_reg) * SQ_W'(b1_reg);
            cc2_reg   <= SQ_W'(c1_reg) * SQ_W'(c1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: wide products as two partials each; median radicands
    // ------------------------------------------------------------------
    logic              v3_reg;
    side_t             side3_reg;
    logic [PL_W-1:0]   pl3_reg, ph3_reg;
    logic [BL_W-1:0]   bla3_reg, bha3_reg, blb3_reg, bhb3_reg, blc3_reg, bhc3_reg;
    logic [MV_W-1:0]   mva3_reg, mvb3_reg, mvc3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side2_reg;
            pl3_reg   <= PL_W'(sxa2_reg) * PL_W'(yz2_reg[DIF_W-1:0]);
            ph3_reg   <= PL_W'(sxa2_reg) * PL_W'(yz2_reg[YZ_W-1:DIF_W]);
            bla3_reg  <= BL_W'(bc2_reg) * BL_W'(sxa2_reg[SUM_W-1:0]);
            bha3_reg  <= BL_W'(bc2_reg) * BL_W'(sxa2_reg[SX_W-1:SUM_W]);
            blb3_reg  <= BL_W'(ac2_reg) * BL_W'(sxb2_reg[SUM_W-1:0]);
            bhb3_reg  <= BL_W'(ac2_reg) * BL_W'(sxb2_reg[SX_W-1:SUM_W]);
            blc3_reg  <= BL_W'(ab2_reg) * BL_W'(sxc2_reg[SUM_W-1:0]);
            bhc3_reg  <= BL_W'(ab2_reg) * BL_W'(sxc2_reg[SX_W-1:SUM_W]);
            mva3_reg  <= ((MV_W'(bb2_reg) + MV_W'(cc2_reg)) << 1) - MV_W'(aa2_reg);
            mvb3_reg  <= ((MV_W'(aa2_reg) + MV_W'(cc2_reg)) << 1) - MV_W'(bb2_reg);
            mvc3_reg  <= ((MV_W'(aa2_reg) + MV_W'(bb2_reg)) << 1) - MV_W'(cc2_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: recombine partials into full radicands
    // ------------------------------------------------------------------
    logic              v4_reg;
    side_t             side4_reg;
    logic [RAD_W-1:0]  radp4_reg, rada4_reg, radb4_reg, radc4_reg;
    logic [RAD_W-1:0]  radma4_reg, radmb4_reg, radmc4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side4_reg  <= side3_reg;
            radp4_reg  <= RAD_W'(pl3_reg) + (RAD_W'(ph3_reg) << DIF_W);
            rada4_reg  <= RAD_W'(bla3_reg) + (RAD_W'(bha3_reg) << SUM_W);
            radb4_reg  <= RAD_W'(blb3_reg) + (RAD_W'(bhb3_reg) << SUM_W);
            radc4_reg  <= RAD_W'(blc3_reg) + (RAD_W'(bhc3_reg) << SUM_W);
            radma4_reg <= RAD_W'(mva3_reg);
            radmb4_reg <= RAD_W'(mvb3_reg);
            radmc4_reg <= RAD_W'(mvc3_reg);
        end
    end

    // ------------------------------------------------------------------
    // Square roots: seven identical bit-per-stage pipes
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] root_p, root_ba, root_bb, root_bc;
    logic [ROOT_W-1:0] root_ma, root_mb, root_mc;

    tmfs_sqrt u_sqrt_p  (.clk(clk), .en(en), .rad(radp4_reg),  .root(root_p));
    tmfs_sqrt u_sqrt_ba (.clk(clk), .en(en), .rad(rada4_reg),  .root(root_ba));
    tmfs_sqrt u_sqrt_bb (.clk(clk), .en(en), .rad(radb4_reg),  .root(root_bb));
    tmfs_sqrt u_sqrt_bc (.clk(clk), .en(en), .rad(radc4_reg),  .root(root_bc));
    tmfs_sqrt u_sqrt_ma (.clk(clk), .en(en), .rad(radma4_reg), .root(root_ma));
    tmfs_sqrt u_sqrt_mb (.clk(clk), .en(en), .rad(radmb4_reg), .root(root_mb));
    tmfs_sqrt u_sqrt_mc (.clk(clk), .en(en), .rad(radmc4_reg), .root(root_mc));

    // sideband travels alongside the root pipes
    logic  vsq_reg   [SQ_STAGES];
    side_t sdsq_reg  [SQ_STAGES];
    side_t sd_root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sdsq_reg[0] <= side4_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                sdsq_reg[i] <= sdsq_reg[i-1];
            end
        end
    end

    assign sd_root = sdsq_reg[SQ_STAGES-1];

    // median = floor(root / 2), clamped to the field
    function automatic logic [QUO_W-1:0] half_sat(input logic [ROOT_W-1:0] r);
        logic [QUO_W-1:0] res;
        if (r[ROOT_W-1:QUO_W+1] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = r[QUO_W:1];
        end
        return res;
    endfunction

    post_t post_next;

    always_comb
    begin
        post_next.ok    = sd_root.ok;
        post_next.perim = sd_root.perim;
        post_next.area  = root_p[AREA_SHIFT +: AREA_W];
        post_next.med_a = half_sat(root_ma);
        post_next.med_b = half_sat(root_mb);
        post_next.med_c = half_sat(root_mc);
    end

    // ------------------------------------------------------------------
    // Divides: heights over 2x, bisectors over the adjacent side sum
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] q_ha, q_hb, q_hc, q_ba, q_bb, q_bc;

    tmfs_div u_div_ha (.clk(clk), .en(en), .num(root_p),  .den(sd_root.dbl_a),  .quo(q_ha));
    tmfs_div u_div_hb (.clk(clk), .en(en), .num(root_p),  .den(sd_root.dbl_b),  .quo(q_hb));
    tmfs_div u_div_hc (.clk(clk), .en(en), .num(root_p),  .den(sd_root.dbl_c),  .quo(q_hc));
    tmfs_div u_div_ba (.clk(clk), .en(en), .num(root_ba), .den(sd_root.pair_a), .quo(q_ba));
    tmfs_div u_div_bb (.clk(clk), .en(en), .num(root_bb), .den(sd_root.pair_b), .quo(q_bb));
    tmfs_div u_div_bc (.clk(clk), .en(en), .num(root_bc), .den(sd_root.pair_c), .quo(q_bc));

    logic  vdv_reg  [DV_STAGES];
    post_t post_reg [DV_STAGES];
    post_t post_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            post_reg[0] <= post_next;
            for (int i = 1; i < DV_STAGES; i++)
            begin
                post_reg[i] <= post_reg[i-1];
            end
        end
    end

    assign post_out = post_reg[DV_STAGES-1];

    // ------------------------------------------------------------------
    // Valid bits for every stage
    // ------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            for (int i = 0; i < SQ_STAGES; i++)
            begin
                vsq_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DV_STAGES; i++)
            begin
                vdv_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg     <= req_valid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            vsq_reg[0] <= v4_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                vsq_reg[i] <= vsq_reg[i-1];
            end
            vdv_reg[0] <= vsq_reg[SQ_STAGES-1];
            for (int i = 1; i < DV_STAGES; i++)
            begin
                vdv_reg[i] <= vdv_reg[i-1];
            end
            out_valid_reg <= vdv_reg[DV_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register: a failed test zeroes every measure
    // ------------------------------------------------------------------
    logic               tri_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [PERIM_W-1:0] perim_reg;
    logic [QUO_W-1:0]   ha_reg, hb_reg, hc_reg, ba_reg, bb_reg, bc_reg;
    logic [QUO_W-1:0]   ma_reg, mb_reg, mc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tri_reg   <= post_out.ok;
            area_reg  <= post_out.ok ? post_out.area  : '0;
            perim_reg <= post_out.ok ? post_out.perim : '0;
            ha_reg    <= post_out.ok ? q_ha : '0;
            hb_reg    <= post_out.ok ? q_hb : '0;
            hc_reg    <= post_out.ok ? q_hc : '0;
            ba_reg    <= post_out.ok ? q_ba : '0;
            bb_reg    <= post_out.ok ? q_bb : '0;
            bc_reg    <= post_out.ok ? q_bc : '0;
            ma_reg    <= post_out.ok ? post_out.med_a : '0;
            mb_reg    <= post_out.ok ? post_out.med_b : '0;
            mc_reg    <= post_out.ok ? post_out.med_c : '0;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign is_triangle = tri_reg;
    assign area        = area_reg;
    assign perimeter   = perim_reg;
    assign height_to_a = ha_reg;
    assign height_to_b = hb_reg;
    assign height_to_c = hc_reg;
    assign bisector_a  = ba_reg;
    assign bisector_b  = bb_reg;
    assign bisector_c  = bc_reg;
    assign median_a    = ma_reg;
    assign median_b    = mb_reg;
    assign median_c    = mc_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `TMFS_ASSERT_IMPL(a_stall_needs_held_beat, req_stall, rsp_valid && rsp_stall)
    `TMFS_ASSERT_IMPL(a_reject_zeroed, rsp_valid && !is_triangle, area == '0 && perimeter == '0)
    `TMFS_ASSERT_IMPL(a_triangle_has_perimeter, rsp_valid && is_triangle, perimeter != '0)
    `TMFS_ASSERT_NEXT(a_held_beat_stays, rsp_valid && rsp_stall, rsp_valid)

endmodule
